FILE: rtl/aho_pkg.sv
// ----------------------------------------------------------------------------
// Additive harmonic oscillator package
// Shared widths, register indexes, microcode control word and the sine
// polynomial used to build the quarter-wave table.
// ----------------------------------------------------------------------------
package aho_pkg;

  localparam int MAX_HARMONICS_DEF   = 8;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  localparam int INC_W      = 31;
  localparam int AMP_W      = 15;
  localparam int GAINS_W    = 64;
  localparam int GAIN_W     = 8;
  localparam int GAIN_COUNT = GAINS_W / GAIN_W;
  localparam int LIMIT_W    = 4;
  localparam int SAMPLE_W   = 16;
  localparam int QSINE_W    = SAMPLE_W - 1;
  localparam int SINE_FRAC  = 15;
  localparam int SUM_SHIFT  = 22;
  localparam int CFG_IDX_W  = 3;

  localparam logic [INC_W-1:0]   BASE_INC_RST = INC_W'(42852282);
  localparam logic [AMP_W-1:0]   AMP_RST      = AMP_W'(1000);
  localparam logic [GAINS_W-1:0] GAINS_RST    = GAINS_W'(128);
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = LIMIT_W'(8);

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_INC  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_INC = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_INC  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_GAINS     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = CFG_IDX_W'(5);

  // microcode
  typedef logic [3:0] upc_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_IF_NONE,
    JMP_IF_MORE
  } jmp_t;

  typedef struct packed {
    logic init;   // clear accumulator, apply restart
    logic harm;   // index from harmonic phase, load amplitude * gain
    logic vib;    // advance vibrato phase, index from it, load depth
    logic mul;    // multiply operand by table sine
    logic acc;    // accumulate product
    logic emit;   // write output register, stalls while it is full
    logic upd;    // advance main phase
    logic last;
    jmp_t jmp;
    upc_t target;
  } ctrl_t;

  localparam upc_t UPC_INIT   = 4'd0;
  localparam upc_t UPC_HADDR  = 4'd1;
  localparam upc_t UPC_HWAIT  = 4'd2;
  localparam upc_t UPC_HMUL   = 4'd3;
  localparam upc_t UPC_HACC   = 4'd4;
  localparam upc_t UPC_FINAL  = 4'd5;
  localparam upc_t UPC_VWAIT  = 4'd6;
  localparam upc_t UPC_VMUL   = 4'd7;
  localparam upc_t UPC_UPDATE = 4'd8;

  localparam ctrl_t CTRL_NOP = '{
    init: 1'b0, harm: 1'b0, vib: 1'b0, mul: 1'b0, acc: 1'b0,
    emit: 1'b0, upd: 1'b0, last: 1'b0, jmp: JMP_NONE, target: UPC_INIT
  };

  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (pc)
      UPC_INIT: begin
        c.init   = 1'b1;
        c.jmp    = JMP_IF_NONE;
        c.target = UPC_FINAL;
      end
      UPC_HADDR:  c.harm = 1'b1;
      UPC_HWAIT:  c.harm = 1'b0;
      UPC_HMUL:   c.mul  = 1'b1;
      UPC_HACC: begin
        c.acc    = 1'b1;
        c.jmp    = JMP_IF_MORE;
        c.target = UPC_HADDR;
      end
      UPC_FINAL: begin
        c.emit = 1'b1;
        c.vib  = 1'b1;
      end
      UPC_VWAIT:  c.vib  = 1'b0;
      UPC_VMUL:   c.mul  = 1'b1;
      UPC_UPDATE: begin
        c.upd  = 1'b1;
        c.last = 1'b1;
      end
      default:    c.last = 1'b1;
    endcase
    return c;
  endfunction

  localparam longint ONE_Q30 = longint'(1) << 30;

  // sin(pi/2 * r / 2^qbits) in unsigned Q0.15, odd polynomial in Q30
  function automatic logic [QSINE_W-1:0] quarter_sine(input int r, input int qbits);
    longint x;
    longint x2;
    longint y;
    longint v;
    x  = longint'(r) * (longint'(1) << (30 - qbits));
    x2 = x * x / ONE_Q30;
    y  = -3864;
    y  = 172272 + y * x2 / ONE_Q30;
    y  = -5026995 + y * x2 / ONE_Q30;
    y  = 85569306 + y * x2 / ONE_Q30;
    y  = -693598670 + y * x2 / ONE_Q30;
    y  = 1686629713 + y * x2 / ONE_Q30;
    y  = y * x / ONE_Q30;
    v  = (y * 32767 + (longint'(1) << 29)) / ONE_Q30;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return QSINE_W'(v);
  endfunction

endpackage

FILE: rtl/additive_harmonic_oscillator_core.sv
// ----------------------------------------------------------------------------
// Additive harmonic oscillator core
// Sums up to MAX_HARMONICS sine harmonics of a vibrato-modulated phase into
// one saturated 16-bit sample per request.
// ----------------------------------------------------------------------------
// Each accepted request yields one sample. A microcoded sequencer drives one
// quarter-wave sine ROM port and one 32x16 multiplier; every harmonic takes a
// four-step loop (address, ROM read, multiply, accumulate), run for
// min(harmonic_limit, MAX_HARMONICS) harmonics, and a new request is accepted
// only once the previous one has finished its program.
// The finished sample waits in an output register, and the emit step stalls
// only while the previous sample still sits there untaken. Configuration
// writes are always ready and must be issued while the core is idle.
module additive_harmonic_oscillator_core #(
  parameter int MAX_HARMONICS   = aho_pkg::MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = aho_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = aho_pkg::PHASE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [aho_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_clipped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [aho_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [aho_pkg::GAINS_W-1:0]   cfg_data
);
  import aho_pkg::*;

  localparam int QB      = SINE_TABLE_BITS - 2;
  localparam int QSIZE   = 1 << QB;
  localparam int CNT_W   = $clog2(MAX_HARMONICS + 1);
  localparam int PROD_W  = INC_W + 1 + SAMPLE_W;
  localparam int ACC_W   = AMP_W + GAIN_W + SAMPLE_W + 1 + CNT_W;
  localparam int PB      = PHASE_BITS;
  localparam int STB     = SINE_TABLE_BITS;

  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(SAMPLE_MIN);

  typedef logic [QSINE_W-1:0] qtab_t [0:QSIZE];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= QSIZE; i++) begin
      t[i] = quarter_sine(i, QB);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // configuration
  logic [INC_W-1:0]   base_inc_r;
  logic [INC_W-1:0]   depth_inc_r;
  logic [INC_W-1:0]   rate_inc_r;
  logic [AMP_W-1:0]   amplitude_r;
  logic [GAINS_W-1:0] gains_r;
  logic [LIMIT_W-1:0] limit_r;

  // sequencer and phase state
  logic            busy_r;
  upc_t            upc_r;
  logic            restart_r;
  logic            out_valid_r;
  logic [PB-1:0]   main_r;
  logic [PB-1:0]   vib_r;
  logic [PB-1:0]   vib_nxt;
  logic [PB-1:0]   main_nxt;

  // datapath
  logic [PB-1:0]              hp_r;
  logic [STB-1:0]             idx_r;
  logic [QSINE_W-1:0]         rom_r;
  logic                       neg_r;
  logic [INC_W-1:0]           mula_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [CNT_W-1:0]           cnt_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       clipped_r;

  ctrl_t                      ctrl;
  logic                       out_full;
  logic                       step_go;
  logic                       jump;
  logic [CNT_W-1:0]           lim_eff;
  logic                       more;
  logic [GAINS_W-1:0]         gains_sh;
  logic [GAIN_W-1:0]          gain_sel;
  logic [QB:0]                qaddr;
  logic signed [SAMPLE_W-1:0] sine_s;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [ACC_W-1:0]    q_full;
  logic signed [PROD_W-1:0]   prod_adj;
  logic signed [PROD_W-1:0]   delta;

  assign ctrl      = ucode(upc_r);
  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_sample  = sample_r;
  assign out_clipped = clipped_r;

  assign out_full = out_valid_r && !out_ready;
  assign step_go  = !(ctrl.emit && out_full);

  assign lim_eff = (32'(limit_r) > MAX_HARMONICS) ? CNT_W'(MAX_HARMONICS) : CNT_W'(limit_r);
  assign more    = 32'(cnt_r) < 32'(lim_eff);

  always_comb begin
    unique case (ctrl.jmp)
      JMP_IF_NONE: jump = (lim_eff == '0);
      JMP_IF_MORE: jump = more;
      default:     jump = 1'b0;
    endcase
  end

  // harmonics past the eighth have no gain byte
  assign gains_sh = gains_r >> {cnt_r, 3'b000};
  assign gain_sel = (32'(cnt_r) < GAIN_COUNT) ? gains_sh[GAIN_W-1:0] : '0;

  // quarter-wave fold of the table index
  assign qaddr  = idx_r[STB-2] ? ((QB+1)'(QSIZE) - {1'b0, idx_r[QB-1:0]})
                               : {1'b0, idx_r[QB-1:0]};
  assign sine_s = neg_r ? -$signed({1'b0, rom_r}) : $signed({1'b0, rom_r});

  // truncate toward zero on the final scale-down
  assign acc_adj = acc_r + (acc_r[ACC_W-1] ? ACC_W'((1 << SUM_SHIFT) - 1) : ACC_W'(0));
  assign q_full  = acc_adj >>> SUM_SHIFT;

  assign prod_adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << SINE_FRAC) - 1) : PROD_W'(0));
  assign delta    = prod_adj >>> SINE_FRAC;

  assign vib_nxt  = vib_r + PB'(rate_inc_r);
  assign main_nxt = main_r + PB'(base_inc_r) + PB'(delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_inc_r  <= BASE_INC_RST;
      depth_inc_r <= '0;
      rate_inc_r  <= '0;
      amplitude_r <= AMP_RST;
      gains_r     <= GAINS_RST;
      limit_r     <= LIMIT_RST;
      busy_r      <= 1'b0;
      upc_r       <= UPC_INIT;
      restart_r   <= 1'b0;
      out_valid_r <= 1'b0;
      main_r      <= '0;
      vib_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BASE_INC:  base_inc_r  <= cfg_data[INC_W-1:0];
          REG_DEPTH_INC: depth_inc_r <= cfg_data[INC_W-1:0];
          REG_RATE_INC:  rate_inc_r  <= cfg_data[INC_W-1:0];
          REG_AMPLITUDE: amplitude_r <= cfg_data[AMP_W-1:0];
          REG_GAINS:     gains_r     <= cfg_data;
          REG_LIMIT:     limit_r     <= cfg_data[LIMIT_W-1:0];
          default:       ;
        endcase
      end

      // a new sample replaces one taken at the same edge
      if (busy_r && step_go && ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (!busy_r) begin
        if (in_valid) begin
          busy_r    <= 1'b1;
          upc_r     <= UPC_INIT;
          restart_r <= in_restart;
        end
      end else if (step_go) begin
        if (jump) begin
          upc_r <= ctrl.target;
        end else if (ctrl.last) begin
          busy_r <= 1'b0;
        end else begin
          upc_r <= upc_r + upc_t'(1);
        end

        if (ctrl.init && restart_r) begin
          main_r <= '0;
          vib_r  <= '0;
        end
        if (ctrl.vib) begin
          vib_r <= vib_nxt;
        end
        if (ctrl.upd) begin
          main_r <= main_nxt;
        end
      end
    end
  end

  // sine ROM, registered read every cycle
  always_ff @(posedge clk) begin
    rom_r <= QTAB[qaddr];
    neg_r <= idx_r[STB-1];
  end

  always_ff @(posedge clk) begin
    if (busy_r && step_go) begin
      if (ctrl.init) begin
        hp_r  <= restart_r ? '0 : main_r;
        acc_r <= '0;
        cnt_r <= '0;
      end
      if (ctrl.harm) begin
        idx_r  <= hp_r[PB-1 -: STB];
        hp_r   <= hp_r + main_r;
        mula_r <= INC_W'(23'(amplitude_r) * 23'(gain_sel));
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      if (ctrl.vib) begin
        idx_r  <= vib_nxt[PB-1 -: STB];
        mula_r <= depth_inc_r;
      end
      if (ctrl.mul) begin
        prod_r <= PROD_W'($signed({1'b0, mula_r}) * sine_s);
      end
      if (ctrl.acc) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (ctrl.emit) begin
        // hold the rail and flag a clip
        if (q_full > Q_MAX) begin
          sample_r  <= SAMPLE_W'(SAMPLE_MAX);
          clipped_r <= 1'b1;
        end else if (q_full < Q_MIN) begin
          sample_r  <= SAMPLE_W'(SAMPLE_MIN);
          clipped_r <= 1'b1;
        end else begin
          sample_r  <= q_full[SAMPLE_W-1:0];
          clipped_r <= 1'b0;
        end
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> busy_r && upc_r == UPC_INIT)
    else $error("accepted request did not start the program");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ctrl.acc |-> 32'(cnt_r) <= MAX_HARMONICS)
    else $error("harmonic count past maximum");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && ctrl.emit && !out_full |=> out_valid)
    else $error("emit step did not present a sample");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_sample == 16'sh7fff || out_sample == -16'sh8000))
    else $error("clipped sample not at a rail");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Additive harmonic oscillator core testbench
// Drives sample requests and register writes through the valid/ready ports,
// predicts every sample with its own phase, vibrato and harmonic-sum model,
// and compares each sample and clip flag in order. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module tb_top;

  import aho_pkg::*;

  localparam int PH_W         = PHASE_BITS_DEF;
  localparam int TBL_BITS     = SINE_TABLE_BITS_DEF;
  localparam int QTR_BITS     = TBL_BITS - 2;
  localparam int HARM_MAX     = MAX_HARMONICS_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 340;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 200000;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  localparam logic [INC_W-1:0] INC_MAX = '1;
  localparam logic [AMP_W-1:0] AMP_MAX = '1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } sample_t;

  class osc_scoreboard;
    logic [INC_W-1:0]           base_inc;
    logic [INC_W-1:0]           depth_inc;
    logic [INC_W-1:0]           rate_inc;
    logic [AMP_W-1:0]           amp;
    logic [GAINS_W-1:0]         gains;
    logic [LIMIT_W-1:0]         limit;
    logic [PH_W-1:0]            main_ph;
    logic [PH_W-1:0]            vib_ph;
    logic signed [SAMPLE_W-1:0] sine_rom[1 << TBL_BITS];
    sample_t                    expected_q[$];
    int                         errors;
    int                         requests;
    int                         restarts;
    int                         samples;
    int                         clip_count;
    int                         cfg_writes;

    function new();
      int quad;
      int r;
      int s;
      for (int i = 0; i < (1 << TBL_BITS); i++) begin
        quad = i >> QTR_BITS;
        r    = i & ((1 << QTR_BITS) - 1);
        s    = quad[0] ? quarter_wave((1 << QTR_BITS) - r) : quarter_wave(r);
        sine_rom[i] = SAMPLE_W'(quad[1] ? -s : s);
      end
      base_inc  = BASE_INC_RST;
      depth_inc = '0;
      rate_inc  = '0;
      amp       = AMP_RST;
      gains     = GAINS_RST;
      limit     = LIMIT_RST;
      main_ph   = '0;
      vib_ph    = '0;
    endfunction

    // odd degree-11 polynomial in Q30, each product truncated toward zero
    function int quarter_wave(int r);
      longint one;
      longint x;
      longint x2;
      longint y;
      longint v;
      one = longint'(1) << 30;
      x   = longint'(r) << (30 - QTR_BITS);
      x2  = x * x / one;
      y   = -3864;
      y   = 172272 + y * x2 / one;
      y   = -5026995 + y * x2 / one;
      y   = 85569306 + y * x2 / one;
      y   = -693598670 + y * x2 / one;
      y   = 1686629713 + y * x2 / one;
      y   = y * x / one;
      v   = (y * 32767 + (longint'(1) << 29)) / one;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return int'(v);
    endfunction

    function logic signed [SAMPLE_W-1:0] sine_at(logic [PH_W-1:0] ph);
      return sine_rom[ph >> (PH_W - TBL_BITS)];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] data);
      cfg_writes++;
      case (idx)
        REG_BASE_INC:  base_inc  = data[INC_W-1:0];
        REG_DEPTH_INC: depth_inc = data[INC_W-1:0];
        REG_RATE_INC:  rate_inc  = data[INC_W-1:0];
        REG_AMPLITUDE: amp       = data[AMP_W-1:0];
        REG_GAINS:     gains     = data;
        REG_LIMIT:     limit     = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic restart);
      longint          acc;
      longint          q;
      longint          vib_step;
      longint          amp_l;
      longint          gain_l;
      longint          sine_l;
      int              lim;
      logic [PH_W-1:0] harm_ph;
      sample_t         exp_s;
      requests++;
      if (restart) begin
        restarts++;
        main_ph = '0;
        vib_ph  = '0;
      end
      lim   = (limit > HARM_MAX) ? HARM_MAX : int'(limit);
      acc   = 0;
      amp_l = longint'(amp);
      for (int n = 1; n <= lim; n++) begin
        harm_ph = PH_W'(main_ph * n);
        gain_l  = longint'(gains[GAIN_W*(n-1) +: GAIN_W]);
        sine_l  = longint'(sine_at(harm_ph));
        acc    += amp_l * gain_l * sine_l;
      end
      q = acc / (longint'(1) << SUM_SHIFT);
      exp_s.clipped = 1'b0;
      if (q > SAMPLE_MAX) begin
        q = SAMPLE_MAX;
        exp_s.clipped = 1'b1;
      end
      if (q < SAMPLE_MIN) begin
        q = SAMPLE_MIN;
        exp_s.clipped = 1'b1;
      end
      exp_s.sample = SAMPLE_W'(q);
      expected_q.push_back(exp_s);
      // vibrato first, then the main phase; a negative step wraps backward
      vib_ph   = vib_ph + PH_W'(rate_inc);
      vib_step = longint'(depth_inc) * longint'(sine_at(vib_ph)) / 32768;
      main_ph  = main_ph + PH_W'(base_inc) + PH_W'(vib_step);
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] s, logic c);
      sample_t exp_s;
      samples++;
      if (c === 1'b1) clip_count++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected sample %0d clipped %0b", s, c);
        return;
      end
      exp_s = expected_q.pop_front();
      if (s !== exp_s.sample || c !== exp_s.clipped) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: sample %0d: expected %0d clipped %0b, got %0d clipped %0b",
                   samples, exp_s.sample, exp_s.clipped, s, c);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftover();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("ERROR: %0d samples never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_restart;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_clipped;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [GAINS_W-1:0]         cfg_data;

  osc_scoreboard sb = new();
  bit            quiet = 1'b0;
  int            items_sent = 0;
  int            phases = 0;

  always #4 clk = ~clk;

  additive_harmonic_oscillator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_clipped(out_clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_sample(out_sample, out_clipped);
  end

  // receiver: ready in random bursts, always ready near the end
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_request(logic restart);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_request(restart);
    items_sent++;
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAINS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold until every sample is out, then let the phase update settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    phases++;
  endtask

  function automatic logic [GAINS_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [GAINS_W-1:0] pick_inc();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAINS_W'(INC_MAX);
      2:       return rand64();
      default: return GAINS_W'($urandom_range(0, 300000000));
    endcase
  endfunction

  task automatic random_voice();
    logic [GAINS_W-1:0] data;
    write_reg(REG_BASE_INC, pick_inc());
    write_reg(REG_DEPTH_INC, pick_inc());
    write_reg(REG_RATE_INC, pick_inc());
    case ($urandom_range(0, 4))
      0:       data = GAINS_W'(AMP_MAX);
      1:       data = rand64();
      default: data = GAINS_W'($urandom_range(0, 32767));
    endcase
    write_reg(REG_AMPLITUDE, data);
    write_reg(REG_GAINS, rand64());
    data = ($urandom_range(0, 3) == 0) ? rand64() : GAINS_W'($urandom_range(0, 15));
    write_reg(REG_LIMIT, data);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand64());
    end_writes();
  endtask

  initial begin
    int notes;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, phases start at zero
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();

    // every register at its maximum, junk above the widths, limit past eight
    write_reg(REG_BASE_INC, '1);
    write_reg(REG_DEPTH_INC, '1);
    write_reg(REG_RATE_INC, '1);
    write_reg(REG_AMPLITUDE, '1);
    write_reg(REG_GAINS, '1);
    write_reg(REG_LIMIT, '1);
    write_reg(REG_SPARE_A, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_SPARE_B, '1);
    end_writes();
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    wait_idle();

    // no harmonics summed
    write_reg(REG_LIMIT, '0);
    end_writes();
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    // quarter-turn steps on one loud harmonic: zero, positive and negative clip
    write_reg(REG_LIMIT, GAINS_W'(1));
    write_reg(REG_GAINS, GAINS_W'(8'hFF));
    write_reg(REG_AMPLITUDE, GAINS_W'(AMP_MAX));
    write_reg(REG_BASE_INC, GAINS_W'(32'h4000_0000));
    write_reg(REG_DEPTH_INC, '0);
    write_reg(REG_RATE_INC, '0);
    end_writes();
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    wait_idle();

    // no base step, deep vibrato: the main phase runs backward half the time
    write_reg(REG_BASE_INC, '0);
    write_reg(REG_DEPTH_INC, GAINS_W'(INC_MAX));
    write_reg(REG_RATE_INC, GAINS_W'(32'h0800_0000));
    write_reg(REG_LIMIT, GAINS_W'(2));
    write_reg(REG_GAINS, GAINS_W'(16'h4080));
    write_reg(REG_AMPLITUDE, GAINS_W'(20000));
    end_writes();
    send_request(1'b1);
    repeat (8) send_request(1'b0);
    wait_idle();

    // random voices, each played as a note that mostly opens with a restart, with stray restarts
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      random_voice();
      notes = $urandom_range(10, 40);
      for (int i = 0; i < notes && items_sent < RANDOM_ITEMS; i++) begin
        if (items_sent >= QUIET_ITEMS) quiet = 1'b1;
        if (i == 0) send_request($urandom_range(0, 7) != 0);
        else        send_request($urandom_range(0, 15) == 0);
      end
      wait_idle();
    end

    sb.flag_leftover();
    $display("Run covered %0d requests (%0d restarts) over %0d register settings, %0d writes.",
             sb.requests, sb.restarts, phases, sb.cfg_writes);
    $display("Checked %0d samples, %0d of them clipped; %0d errors.",
             sb.samples, sb.clip_count, sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
